// ===== rtl/core/rcfd_pkg.sv =====
// ----------------------------------------------------------------------------
// rcfd_pkg
// Shared types and constants for the remote-control frame decoder.
// ----------------------------------------------------------------------------
package rcfd_pkg;

  localparam int FRAME_BYTES = 18;
  localparam int CNT_W       = 5;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FRAME_BYTES);
  localparam logic [CNT_W-1:0] CNT_OVER = CNT_W'(FRAME_BYTES + 1);

  // input opcodes
  localparam logic [1:0] OP_DATA = 2'd0;
  localparam logic [1:0] OP_EOF  = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_CENTRE   = 2'd0;
  localparam logic [1:0] REG_DEADBAND = 2'd1;
  localparam logic [1:0] REG_TIMEOUT  = 2'd2;

  localparam logic [10:0] CENTRE_RST   = 11'd1024;
  localparam logic [10:0] DEADBAND_RST = 11'd10;
  localparam logic [15:0] TIMEOUT_RST  = 16'd1500;

  localparam logic [3:0] SW_BOTH_DOWN = 4'hA;

  // command queue between front and back
  localparam int CMD_DEPTH = 2;
  localparam int CMD_PTR_W = 1;
  localparam int CMD_CNT_W = 2;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic signed [11:0] stick_right_h;
    logic signed [11:0] stick_right_v;
    logic signed [11:0] stick_left_h;
    logic signed [11:0] stick_left_v;
    logic signed [15:0] wheel;
    logic        [3:0]  switches;
    logic signed [15:0] mouse_x;
    logic signed [15:0] mouse_y;
    logic signed [15:0] mouse_z;
    logic        [15:0] mouse_buttons;
    logic        [15:0] key_bits;
    logic               link_lost;
  } out_word_t;

  typedef enum logic [0:0] {
    CMD_FRAME = 1'b0,
    CMD_LOSS  = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                       kind;
    logic [FRAME_BYTES-1:0][7:0]     frame;
  } cmd_t;

endpackage

// ===== rtl/core/rcfd_front.sv =====
// ----------------------------------------------------------------------------
// rcfd_front
// Collects frame bytes, checks frame length, runs the loss timer and issues
// decode / loss commands.
// ----------------------------------------------------------------------------
module rcfd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  rcfd_pkg::in_word_t in_word,
  input  logic [15:0]       loss_timeout,
  output logic              cmd_push,
  output rcfd_pkg::cmd_t    cmd
);

  logic [7:0]                  buf_r [rcfd_pkg::FRAME_BYTES];
  logic [rcfd_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [15:0]                 ticks_r, ticks_nxt;
  logic                        lost_r, lost_nxt;
  logic [15:0]                 tick_inc;

  assign tick_inc = (ticks_r == 16'hFFFF) ? ticks_r : ticks_r + 16'd1;

  always_comb begin
    for (int i = 0; i < rcfd_pkg::FRAME_BYTES; i++) begin
      cmd.frame[i] = buf_r[i];
    end
    cmd.kind  = rcfd_pkg::CMD_FRAME;
    cmd_push  = 1'b0;
    cnt_nxt   = cnt_r;
    ticks_nxt = ticks_r;
    lost_nxt  = lost_r;
    if (accept) begin
      unique case (in_word.opcode)
        rcfd_pkg::OP_DATA: begin
          if (cnt_r < rcfd_pkg::CNT_FULL) cnt_nxt = cnt_r + 1'b1;
          else                            cnt_nxt = rcfd_pkg::CNT_OVER;
        end
        rcfd_pkg::OP_EOF: begin
          cnt_nxt = '0;
          if (cnt_r == rcfd_pkg::CNT_FULL) begin
            cmd_push  = 1'b1;
            ticks_nxt = '0;
            lost_nxt  = 1'b0;
          end
        end
        rcfd_pkg::OP_TICK: begin
          ticks_nxt = tick_inc;
          if (!lost_r && tick_inc >= loss_timeout) begin
            lost_nxt = 1'b1;
            cmd_push = 1'b1;
            cmd.kind = rcfd_pkg::CMD_LOSS;
          end
        end
        default: ;  // unused opcode, ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      ticks_r <= '0;
      lost_r  <= 1'b0;
    end else begin
      cnt_r   <= cnt_nxt;
      ticks_r <= ticks_nxt;
      lost_r  <= lost_nxt;
    end
  end

  // frame bytes: payload, no reset
  always_ff @(posedge clk) begin
    if (accept && in_word.opcode == rcfd_pkg::OP_DATA && cnt_r < rcfd_pkg::CNT_FULL) begin
      buf_r[cnt_r] <= in_word.data_byte;
    end
  end

endmodule

// ===== rtl/core/rcfd_queue.sv =====
// ----------------------------------------------------------------------------
// rcfd_queue
// Two-entry command queue decoupling the front from the back.
// ----------------------------------------------------------------------------
module rcfd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  rcfd_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output rcfd_pkg::cmd_t head
);

  rcfd_pkg::cmd_t                 mem_r [rcfd_pkg::CMD_DEPTH];
  logic [rcfd_pkg::CMD_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [rcfd_pkg::CMD_CNT_W-1:0] count_r, count_nxt;

  assign full  = (count_r == rcfd_pkg::CMD_CNT_W'(rcfd_pkg::CMD_DEPTH));
  assign valid = (count_r != '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop)      count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_cmd;
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full && !pop))
    else $error("command queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && !valid))
    else $error("command queue underflow");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
      count_r <= rcfd_pkg::CMD_CNT_W'(rcfd_pkg::CMD_DEPTH))
    else $error("command queue count out of range");
  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
      (count_r == '0 || full) |-> (wr_ptr_r == rd_ptr_r))
    else $error("command queue pointers disagree with count");
`endif

endmodule

// ===== rtl/core/rcfd_back.sv =====
// ----------------------------------------------------------------------------
// rcfd_back
// Executes decode / loss commands: unpacks channels, centres them, applies
// the deadband and holds the result word until it is taken.
// ----------------------------------------------------------------------------
module rcfd_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_valid,
  input  rcfd_pkg::cmd_t      cmd,
  output logic                cmd_pop,
  input  logic [10:0]         centre_offset,
  input  logic [10:0]         deadband,
  output logic                out_empty,
  input  logic                out_pop,
  output rcfd_pkg::out_word_t out_word
);

  rcfd_pkg::out_word_t out_r, res;
  logic                out_valid_r;
  logic [63:0]         mouse_r;
  logic [15:0]         key_r;
  logic [10:0]         c0, c1, c2, c3;
  logic [15:0]         wraw;

  function automatic logic signed [11:0] stick_db(logic [10:0] raw, logic [10:0] ctr,
                                                  logic [10:0] db);
    logic signed [12:0] v;
    logic signed [12:0] d;
    v = $signed({2'b00, raw}) - $signed({2'b00, ctr});
    d = $signed({2'b00, db});
    if (v < d && v > -d) return '0;
    return v[11:0];
  endfunction

  function automatic logic signed [15:0] wheel_db(logic [15:0] raw, logic [10:0] ctr,
                                                  logic [10:0] db);
    logic [15:0]        wu;
    logic signed [16:0] w;
    logic signed [16:0] d;
    wu = raw - {5'b0, ctr};
    w  = $signed({wu[15], wu});
    d  = $signed({6'b0, db});
    if (w < d && w > -d) return '0;
    return wu;
  endfunction

  assign cmd_pop   = cmd_valid && (!out_valid_r || out_pop);
  assign out_empty = !out_valid_r;
  assign out_word  = out_r;

  // 11-bit channels packed LSB first
  assign c0   = {cmd.frame[1][2:0], cmd.frame[0]};
  assign c1   = {cmd.frame[2][5:0], cmd.frame[1][7:3]};
  assign c2   = {cmd.frame[4][0], cmd.frame[3], cmd.frame[2][7:6]};
  assign c3   = {cmd.frame[5][3:0], cmd.frame[4][7:1]};
  assign wraw = {cmd.frame[17], cmd.frame[16]};

  always_comb begin
    res.mouse_x       = mouse_r[15:0];
    res.mouse_y       = mouse_r[31:16];
    res.mouse_z       = mouse_r[47:32];
    res.mouse_buttons = mouse_r[63:48];
    res.key_bits      = key_r;
    unique case (cmd.kind)
      rcfd_pkg::CMD_FRAME: begin
        res.stick_right_h = stick_db(c0, centre_offset, deadband);
        res.stick_right_v = stick_db(c1, centre_offset, deadband);
        res.stick_left_h  = stick_db(c2, centre_offset, deadband);
        res.stick_left_v  = stick_db(c3, centre_offset, deadband);
        res.wheel         = wheel_db(wraw, centre_offset, deadband);
        res.switches      = cmd.frame[5][7:4];
        res.mouse_x       = {cmd.frame[7], cmd.frame[6]};
        res.mouse_y       = {cmd.frame[9], cmd.frame[8]};
        res.mouse_z       = {cmd.frame[11], cmd.frame[10]};
        res.mouse_buttons = {cmd.frame[13], cmd.frame[12]};
        res.key_bits      = {cmd.frame[15], cmd.frame[14]};
        res.link_lost     = 1'b0;
      end
      rcfd_pkg::CMD_LOSS: begin
        res.stick_right_h = '0;
        res.stick_right_v = '0;
        res.stick_left_h  = '0;
        res.stick_left_v  = '0;
        res.wheel         = '0;
        res.switches      = rcfd_pkg::SW_BOTH_DOWN;
        res.link_lost     = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      mouse_r     <= '0;
      key_r       <= '0;
    end else begin
      if (cmd_pop)      out_valid_r <= 1'b1;
      else if (out_pop) out_valid_r <= 1'b0;
      if (cmd_pop && cmd.kind == rcfd_pkg::CMD_FRAME) begin
        mouse_r <= {res.mouse_buttons, res.mouse_z, res.mouse_y, res.mouse_x};
        key_r   <= res.key_bits;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) out_r <= res;
  end

endmodule

// ===== rtl/core/rc_frame_decoder_deadband.sv =====
// ----------------------------------------------------------------------------
// rc_frame_decoder_deadband
// Remote-control receiver frame decoder with centring and deadband.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_push / in_full / in_word): one word per cycle carrying
//    a data byte, an end-of-frame marker or a timer tick. A word is taken on
//    a clock edge with in_push high and in_full low.
//  - Result channel (out_empty / out_pop / out_word): the oldest result sits
//    on out_word while out_empty is low; out_pop takes it.
//  - Config port (cfg_we / cfg_addr / cfg_wdata): single-cycle register write,
//    0 centre offset, 1 deadband, 2 loss timeout. Write only while idle.
//  - Path: the end-of-frame or tick word that causes a result pushes a
//    command into the queue on the accepting edge; the output register is
//    loaded from the queue head when it is free or being popped.
//  - Throughput: one input word per cycle, sustained, as long as results are
//    drained, and the back end then retires one command per cycle.
//  - Stall: when out_pop is held low the output register holds, the two-entry
//    command queue fills, and in_full then rises until the back takes one.
//  - Reset (rst_n low, synchronous): byte count, tick count, lost flag, saved
//    mouse/key values and all handshake state are cleared; registers return
//    to centre 1024, deadband 10, timeout 1500.
// ----------------------------------------------------------------------------
module rc_frame_decoder_deadband (
  input  logic                clk,
  input  logic                rst_n,
  // input channel
  input  logic                in_push,
  output logic                in_full,
  input  rcfd_pkg::in_word_t  in_word,
  // result channel
  output logic                out_empty,
  input  logic                out_pop,
  output rcfd_pkg::out_word_t out_word,
  // configuration
  input  logic                cfg_we,
  input  logic [1:0]          cfg_addr,
  input  logic [15:0]         cfg_wdata
);

  logic [10:0]    centre_r;
  logic [10:0]    deadband_r;
  logic [15:0]    timeout_r;

  logic           in_accept;
  logic           cmd_push;
  rcfd_pkg::cmd_t cmd_in;
  rcfd_pkg::cmd_t cmd_head;
  logic           cmd_valid;
  logic           cmd_pop;
  logic           q_full;

  // the front never stalls on its own; only a full queue holds the input
  assign in_full   = q_full;
  assign in_accept = in_push && !q_full;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      centre_r   <= rcfd_pkg::CENTRE_RST;
      deadband_r <= rcfd_pkg::DEADBAND_RST;
      timeout_r  <= rcfd_pkg::TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        rcfd_pkg::REG_CENTRE:   centre_r   <= cfg_wdata[10:0];
        rcfd_pkg::REG_DEADBAND: deadband_r <= cfg_wdata[10:0];
        rcfd_pkg::REG_TIMEOUT:  timeout_r  <= cfg_wdata;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // front: byte collection, length check, loss timer
  rcfd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (in_accept),
    .in_word      (in_word),
    .loss_timeout (timeout_r),
    .cmd_push     (cmd_push),
    .cmd          (cmd_in)
  );

  // command queue carries the full frame so the front can refill its buffer
  rcfd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cmd_push),
    .push_cmd (cmd_in),
    .full     (q_full),
    .pop      (cmd_pop),
    .valid    (cmd_valid),
    .head     (cmd_head)
  );

  // back: unpack, centre, deadband, output register
  rcfd_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd_head),
    .cmd_pop       (cmd_pop),
    .centre_offset (centre_r),
    .deadband      (deadband_r),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_word      (out_word)
  );

endmodule
